// File: rtl/assert_macros.svh
// Assertion macros shared by the civil date to tick count RTL.
// Each macro expects clk and rst_n to be visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/cdt_pkg.sv
// Package for the civil date to tick count block: field widths, tick constants,
// month tables, error codes and the stage payload structs. No dependencies.
package cdt_pkg;

    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int MsW     = 10;
    localparam int TickW   = 62;
    localparam int ErrW    = 2;

    // Day number stays below 2^22 for every valid date.
    localparam int DaysW     = 22;
    // Unchecked time fields at their full widths stay below 2^41 ticks.
    localparam int TimeW     = 41;
    // Ticks per day is 2^14 times an odd 26-bit factor.
    localparam int DayShift  = 14;
    localparam int DayProdW  = TickW - DayShift;

    localparam logic [YearW-1:0]    MaxYear     = 14'd9999;
    localparam logic [MonthW-1:0]   MonthsPerYr = 4'd12;
    localparam logic [25:0]         DayFactor   = 26'd52734375;
    localparam logic [TimeW-1:0]    TicksPerHour   = 41'd36000000000;
    localparam logic [TimeW-1:0]    TicksPerMinute = 41'd600000000;
    localparam logic [TimeW-1:0]    TicksPerSecond = 41'd10000000;
    localparam logic [TimeW-1:0]    TicksPerMs     = 41'd10000;

    // floor(v / 100) == (v * Recip100) >> Recip100Shift for v below 2^14.
    localparam logic [12:0] Recip100      = 13'd5243;
    localparam int          Recip100Shift = 19;

    localparam logic [8:0] CumCommon [13] =
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
    localparam logic [8:0] CumLeap [13] =
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

    typedef enum logic [ErrW-1:0] {
        ERR_NONE    = 2'd0,
        ERR_RANGE   = 2'd1,
        ERR_DAY_LEN = 2'd2
    } cdt_err_t;

    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
        logic [MsW-1:0]     millisecond;
    } cdt_date_t;

    typedef struct packed {
        logic [DaysW-1:0]   days;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
        logic [MsW-1:0]     millisecond;
        cdt_err_t           err;
    } cdt_day_t;

    typedef struct packed {
        logic [DayProdW-1:0] day_prod;
        logic [TimeW-1:0]    time_ticks;
        cdt_err_t            err;
    } cdt_scaled_t;

    typedef struct packed {
        logic [TickW-1:0] tick_count;
        cdt_err_t         err;
    } cdt_result_t;

    // Days before the first of the month; zero for month codes outside 1..12.
    function automatic logic [8:0] cum_before(input logic [MonthW-1:0] month,
                                              input logic leap);
        logic [MonthW-1:0] idx;
        begin
            idx = month - 4'd1;
            if (idx > 4'd11)
            begin
                return 9'd0;
            end
            return leap ? CumLeap[idx] : CumCommon[idx];
        end
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        begin
            unique case (month)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: rtl/cdt_date_if.sv
// Input channel of the civil date to tick count block: valid/ready and the date fields.
// Depends on cdt_pkg for the field widths.
interface cdt_date_if import cdt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [YearW-1:0]     year;
    logic [MonthW-1:0]    month;
    logic [DayW-1:0]      day;
    logic [HourW-1:0]     hour;
    logic [MinuteW-1:0]   minute;
    logic [SecondW-1:0]   second;
    logic [MsW-1:0]       millisecond;

    modport source (output valid, year, month, day, hour, minute, second, millisecond,
                    input ready);
    modport sink   (input valid, year, month, day, hour, minute, second, millisecond,
                    output ready);
endinterface

// File: rtl/cdt_tick_if.sv
// Output channel of the civil date to tick count block: valid/ready, ticks and error code.
// Depends on cdt_pkg for the field widths.
interface cdt_tick_if import cdt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TickW-1:0] tick_count;
    logic [ErrW-1:0]  error_code;

    modport source (output valid, tick_count, error_code, input ready);
    modport sink   (input valid, tick_count, error_code, output ready);
endinterface

// File: rtl/civil_date_to_tick_count_core.sv
// Civil date to tick count core.
//
// The date channel carries one proleptic Gregorian date and time of day per
// beat; the ticks channel returns one beat per date with the count of 100 ns
// ticks since 0001-01-01 00:00 and an error code. A year outside 1..9999, a
// month outside 1..12 or a zero day gives error code 1; a day beyond the
// month's length gives error code 2. Both errors report zero ticks. Time
// fields are not checked and are added at face value.
//
// The core is a four-register pipeline: input register, day number, tick
// scaling, result register. A beat taken in passes through them in that order
// to reach the ticks channel, and one beat is taken every cycle while the
// receiver keeps up. When the receiver stalls, the result register holds
// and the stages behind it keep filling, so four beats are held before date
// ready drops. Reset empties every stage; no results are pending after it.
module civil_date_to_tick_count_core import cdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cdt_date_if.sink   date,
    cdt_tick_if.source ticks
);

`include "assert_macros.svh"

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        v1_next, v2_next, v3_next, v4_next;
    logic        rdy1, rdy2, rdy3, rdy4;

    cdt_date_t   s1_reg, s1_next;
    cdt_day_t    s2_reg, s2_next;
    cdt_scaled_t s3_reg, s3_next;
    cdt_result_t s4_reg, s4_next;

    cdt_day_t    day_d;
    cdt_scaled_t scaled_d;

    // A stage can take a new beat when it is empty or its content moves on.
    assign rdy4 = !v4_reg || ticks.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign date.ready = rdy1;

    cdt_day_calc u_day_calc
    (
        .date_q (s1_reg),
        .day_d  (day_d)
    );

    cdt_tick_scale u_tick_scale
    (
        .day_q    (s2_reg),
        .scaled_d (scaled_d)
    );

    always_comb
    begin
        v1_next = rdy1 ? date.valid : v1_reg;
        v2_next = rdy2 ? v1_reg     : v2_reg;
        v3_next = rdy3 ? v2_reg     : v3_reg;
        v4_next = rdy4 ? v3_reg     : v4_reg;

        s1_next = s1_reg;
        if (rdy1)
        begin
            s1_next.year        = date.year;
            s1_next.month       = date.month;
            s1_next.day         = date.day;
            s1_next.hour        = date.hour;
            s1_next.minute      = date.minute;
            s1_next.second      = date.second;
            s1_next.millisecond = date.millisecond;
        end

        s2_next = rdy2 ? day_d    : s2_reg;
        s3_next = rdy3 ? scaled_d : s3_reg;

        s4_next = s4_reg;
        if (rdy4)
        begin
            s4_next.err = s3_reg.err;
            if (s3_reg.err == ERR_NONE)
            begin
                s4_next.tick_count = {s3_reg.day_prod, DayShift'(0)}
                                   + TickW'(s3_reg.time_ticks);
            end
            else
            begin
                s4_next.tick_count = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
    end

    assign ticks.valid      = v4_reg;
    assign ticks.tick_count = s4_reg.tick_count;
    assign ticks.error_code = s4_reg.err;

    `ASSERT_SAME(a_err_zero_ticks, ticks.valid && (s4_reg.err != ERR_NONE), s4_reg.tick_count == '0)
    `ASSERT_NEXT(a_out_held, ticks.valid && !ticks.ready, ticks.valid && $stable(s4_reg))
    `ASSERT_SAME(a_full_when_blocked, !date.ready, v1_reg && v2_reg && v3_reg && v4_reg)
    `ASSERT_NEXT(a_accept_fills_input, date.valid && date.ready, v1_reg)

endmodule

// File: rtl/cdt_day_calc.sv
// Date checking and day number: validates year, month and day, applies the
// 4/100/400 leap rule and the month tables. Depends on cdt_pkg.
module cdt_day_calc import cdt_pkg::*;
(
    input  cdt_date_t date_q,
    output cdt_day_t  day_d
);

    logic [YearW-1:0]      y;
    logic [YearW+12:0]     prod_y;
    logic [YearW+12:0]     prod_yr;
    logic [7:0]            q100_y;
    logic [7:0]            q100_yr;
    logic                  leap;
    logic                  range_bad;
    logic                  len_bad;
    logic [8:0]            cum;
    cdt_err_t              err;

    assign y = date_q.year - 14'd1;

    // Reciprocal multiply gives the quotient by 100 for both year and year - 1.
    assign prod_y  = 27'(y) * 27'(Recip100);
    assign prod_yr = 27'(date_q.year) * 27'(Recip100);
    assign q100_y  = prod_y[Recip100Shift +: 8];
    assign q100_yr = prod_yr[Recip100Shift +: 8];

    // A year is a multiple of 100 (or 400) exactly when its quotient differs
    // from that of the year before.
    assign leap = (date_q.year[1:0] == 2'b00) &&
                  ((q100_y == q100_yr) || (q100_y[7:2] != q100_yr[7:2]));

    assign range_bad = (date_q.year == '0) || (date_q.year > MaxYear) ||
                       (date_q.month == '0) || (date_q.month > MonthsPerYr) ||
                       (date_q.day == '0);
    assign len_bad   = date_q.day > month_len(date_q.month, leap);
    assign cum       = cum_before(date_q.month, leap);

    always_comb
    begin
        priority if (range_bad)
        begin
            err = ERR_RANGE;
        end
        else if (len_bad)
        begin
            err = ERR_DAY_LEN;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    always_comb
    begin
        day_d.days = DaysW'(y) * DaysW'(365) + DaysW'(y[YearW-1:2])
                   - DaysW'(q100_y) + DaysW'(q100_y[7:2])
                   + DaysW'(cum) + DaysW'(date_q.day) - DaysW'(1);
        day_d.hour        = date_q.hour;
        day_d.minute      = date_q.minute;
        day_d.second      = date_q.second;
        day_d.millisecond = date_q.millisecond;
        day_d.err         = err;
    end

endmodule

// File: rtl/cdt_tick_scale.sv
// Tick scaling: multiplies the day number by the odd part of ticks per day and
// sums the time-of-day terms. Depends on cdt_pkg.
module cdt_tick_scale import cdt_pkg::*;
(
    input  cdt_day_t    day_q,
    output cdt_scaled_t scaled_d
);

    logic [TimeW-1:0] hour_ticks;
    logic [TimeW-1:0] minute_ticks;
    logic [TimeW-1:0] second_ticks;
    logic [TimeW-1:0] ms_ticks;

    assign hour_ticks   = TimeW'(day_q.hour) * TicksPerHour;
    assign minute_ticks = TimeW'(day_q.minute) * TicksPerMinute;
    assign second_ticks = TimeW'(day_q.second) * TicksPerSecond;
    assign ms_ticks     = TimeW'(day_q.millisecond) * TicksPerMs;

    // The power-of-two part of ticks per day is applied as a shift in the next stage.
    assign scaled_d.day_prod   = DayProdW'(day_q.days) * DayProdW'(DayFactor);
    assign scaled_d.time_ticks = hour_ticks + minute_ticks + second_ticks + ms_ticks;
    assign scaled_d.err        = day_q.err;

endmodule

// File: tb/civil_date_to_tick_count_core_tb.sv
// Self-checking testbench for civil_date_to_tick_count_core: directed dates, then random dates.
// Depends on cdt_pkg, cdt_date_if and cdt_tick_if from the RTL.
`timescale 1ns / 1ps

module civil_date_to_tick_count_core_tb;
    import cdt_pkg::*;

    localparam longint unsigned DayTicks    = 64'd864000000000;
    localparam longint unsigned HourTicks   = 64'd36000000000;
    localparam longint unsigned MinuteTicks = 64'd600000000;
    localparam longint unsigned SecondTicks = 64'd10000000;
    localparam longint unsigned MsTicks     = 64'd10000;

    localparam int RandomDates = 1200;
    localparam int QuietLimit  = 2000;
    localparam int LongHold    = 120;
    localparam int DrainCycles = 8;

    typedef struct packed {
        cdt_date_t   date;
        logic        known;
        cdt_result_t want;
    } date_row_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE
    } rx_mode_t;

    localparam int DirN = 25;
    localparam date_row_t DirRows [DirN] = '{
        '{'{14'd1,     4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_NONE}},
        '{'{14'd1,     4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1,
          '{62'd864000000000, ERR_NONE}},
        '{'{14'd9999,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999},  1'b1,
          '{62'd3155378975999990000, ERR_NONE}},
        '{'{14'd9999,  4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023}, 1'b0, '{62'd0, ERR_NONE}},
        '{'{14'd0,     4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd10000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd16383, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023}, 1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd2023,  4'd0,  5'd1,  5'd1,  6'd1,  6'd1,  10'd1},    1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd2023,  4'd13, 5'd1,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd2023,  4'd15, 5'd1,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd2023,  4'd6,  5'd0,  5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd0,     4'd0,  5'd0,  5'd31, 6'd63, 6'd63, 10'd1023}, 1'b1, '{62'd0, ERR_RANGE}},
        '{'{14'd2000,  4'd2,  5'd29, 5'd12, 6'd0,  6'd0,  10'd0},    1'b0, '{62'd0, ERR_NONE}},
        '{'{14'd1900,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd2100,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd2023,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd2024,  4'd2,  5'd29, 5'd6,  6'd30, 6'd15, 10'd500},  1'b0, '{62'd0, ERR_NONE}},
        '{'{14'd2400,  4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},    1'b0, '{62'd0, ERR_NONE}},
        '{'{14'd2024,  4'd2,  5'd30, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd2023,  4'd4,  5'd31, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd2023,  4'd11, 5'd31, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd100,   4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},    1'b1, '{62'd0, ERR_DAY_LEN}},
        '{'{14'd4,     4'd2,  5'd29, 5'd0,  6'd0,  6'd0,  10'd0},    1'b0, '{62'd0, ERR_NONE}},
        '{'{14'd2023,  4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999},  1'b0, '{62'd0, ERR_NONE}},
        '{'{14'd1970,  4'd1,  5'd1,  5'd12, 6'd34, 6'd56, 10'd789},  1'b0, '{62'd0, ERR_NONE}}
    };

    logic clk;
    logic rst_n;

    cdt_date_if date_ch ();
    cdt_tick_if tick_ch ();

    civil_date_to_tick_count_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .date  (date_ch),
        .ticks (tick_ch)
    );

    cdt_result_t pending_ticks [$];
    int          mismatches = 0;
    int          dates_sent = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic is_leap_year(input logic [YearW-1:0] yr);
        begin
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        end
    endfunction

    function automatic logic [DayW-1:0] days_in_month(input logic [YearW-1:0] yr,
                                                      input logic [MonthW-1:0] mo);
        begin
            case (mo)
                4'd2:                    return is_leap_year(yr) ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
                default:                 return 5'd31;
            endcase
        end
    endfunction

    function automatic cdt_result_t predict_ticks(input cdt_date_t d);
        cdt_result_t     r;
        longint unsigned y;
        longint unsigned days_before;
        longint unsigned day_num;
        longint unsigned total;
        begin
            r.tick_count = '0;
            r.err        = ERR_NONE;
            if (d.year == 0 || d.year > MaxYear || d.month == 0 || d.month > MonthsPerYr
                || d.day == 0)
            begin
                r.err = ERR_RANGE;
            end
            else if (d.day > days_in_month(d.year, d.month))
            begin
                r.err = ERR_DAY_LEN;
            end
            else
            begin
                days_before = 0;
                for (int m = 1; m < int'(d.month); m++)
                begin
                    days_before = days_before + 64'(days_in_month(d.year, MonthW'(m)));
                end
                y       = 64'(d.year) - 64'd1;
                day_num = y * 64'd365 + y / 64'd4 - y / 64'd100 + y / 64'd400
                        + days_before + 64'(d.day) - 64'd1;
                total   = day_num * DayTicks
                        + 64'(d.hour) * HourTicks
                        + 64'(d.minute) * MinuteTicks
                        + 64'(d.second) * SecondTicks
                        + 64'(d.millisecond) * MsTicks;
                r.tick_count = total[TickW-1:0];
            end
            return r;
        end
    endfunction

    // Offers one date beat, opening a new burst after a random gap when the
    // current one is used up, and files the expected result once it is taken.
    task automatic convert_date(input cdt_date_t d, input cdt_result_t want);
        int gap;
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    date_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            date_ch.valid       <= 1'b1;
            date_ch.year        <= d.year;
            date_ch.month       <= d.month;
            date_ch.day         <= d.day;
            date_ch.hour        <= d.hour;
            date_ch.minute      <= d.minute;
            date_ch.second      <= d.second;
            date_ch.millisecond <= d.millisecond;
            do
            begin
                @(posedge clk);
            end
            while (!date_ch.ready);
            pending_ticks.push_back(want);
            dates_sent++;
        end
    endtask

    initial
    begin
        cdt_date_t        d;
        logic [63:0]      noise;
        logic [DayW-1:0]  len;
        int               pick;

        rst_n               <= 1'b0;
        date_ch.valid       <= 1'b0;
        date_ch.year        <= '0;
        date_ch.month       <= '0;
        date_ch.day         <= '0;
        date_ch.hour        <= '0;
        date_ch.minute      <= '0;
        date_ch.second      <= '0;
        date_ch.millisecond <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DirN; i++)
        begin
            convert_date(DirRows[i].date,
                         DirRows[i].known ? DirRows[i].want : predict_ticks(DirRows[i].date));
        end

        for (int i = 0; i < RandomDates; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 88)
            begin
                noise = {$urandom, $urandom};
                d     = noise[$bits(cdt_date_t)-1:0];
            end
            else
            begin
                // Century years exercise the 100 and 400 rules of the leap test.
                if (pick < 10)
                begin
                    d.year = YearW'(100 * $urandom_range(1, 99));
                end
                else
                begin
                    d.year = YearW'($urandom_range(1, 9999));
                end
                d.month = MonthW'($urandom_range(1, 12));
                len     = days_in_month(d.year, d.month);
                d.day   = DayW'($urandom_range(1, len));
                if (pick >= 70 && pick < 80)
                begin
                    d.hour        = HourW'($urandom_range(0, 31));
                    d.minute      = MinuteW'($urandom_range(0, 63));
                    d.second      = SecondW'($urandom_range(0, 63));
                    d.millisecond = MsW'($urandom_range(0, 1023));
                end
                else
                begin
                    d.hour        = HourW'($urandom_range(0, 23));
                    d.minute      = MinuteW'($urandom_range(0, 59));
                    d.second      = SecondW'($urandom_range(0, 59));
                    d.millisecond = MsW'($urandom_range(0, 999));
                end
                if (pick >= 80 && len < 5'd31)
                begin
                    d.day = DayW'($urandom_range(len + 1, 31));
                end
            end
            convert_date(d, predict_ticks(d));
        end

        date_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_ticks.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("civil_date_to_tick_count_core_tb: done, clean");
        end
        else
        begin
            $display("civil_date_to_tick_count_core_tb: done, errors");
        end
        $finish;
    end

    // The receiver switches among stall patterns of random length, and once,
    // well into the run, refuses results long enough to back up the pipeline.
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        logic     hold_done;

        mode      = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        tick_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && dates_sent >= 300)
            begin
                hold_done = 1'b1;
                hold_left = LongHold;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tick_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_STEADY: tick_ch.ready <= 1'b1;
                    RX_HALF:   tick_ch.ready <= ($urandom_range(0, 1) == 1);
                    RX_MOSTLY: tick_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:   tick_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cdt_result_t want;
        if (rst_n && tick_ch.valid && tick_ch.ready)
        begin
            if (pending_ticks.size() == 0)
            begin
                $display("%0t: result beat with none expected, got ticks %0d error %0d",
                         $time, tick_ch.tick_count, tick_ch.error_code);
                mismatches++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                if (tick_ch.tick_count !== want.tick_count)
                begin
                    $display("%0t: tick_count mismatch, expected %0d, got %0d",
                             $time, want.tick_count, tick_ch.tick_count);
                    mismatches++;
                end
                if (tick_ch.error_code !== want.err)
                begin
                    $display("%0t: error_code mismatch, expected %0d, got %0d",
                             $time, want.err, tick_ch.error_code);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((date_ch.valid && date_ch.ready) || (tick_ch.valid && tick_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("civil_date_to_tick_count_core_tb: done, errors");
                $finish;
            end
        end
    end

endmodule
